### hw/rtl/radiance_accumulation_buffer_defines.svh
// ---------------------------------------------------------------------------
// Radiance accumulation buffer assertion macros
// Shared concurrent assertion forms for the accumulation buffer RTL.
// ---------------------------------------------------------------------------
`ifndef RADIANCE_ACCUMULATION_BUFFER_DEFINES_SVH
`define RADIANCE_ACCUMULATION_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rab assertion failed");

// Next-cycle implication, disabled during reset.
`define RAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rab assertion failed");

`endif

### hw/rtl/rab_pkg.sv
// ---------------------------------------------------------------------------
// Radiance accumulation buffer package
// Types, codes and constants shared by the accumulation buffer modules.
// ---------------------------------------------------------------------------
package rab_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int SUM_BITS_DEF   = 40;

	localparam int OP_W       = 3;
	localparam int COORD_W    = 8;
	localparam int DIM_W      = 9;
	localparam int COLOR_W    = 24;
	localparam int CHAN_W     = 16;
	localparam int CNT_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int DIV_NUM_W  = 50;
	localparam int DIV_STEP_W = 4;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR      = 3'd0,
		OP_ADVANCE    = 3'd1,
		OP_SET_ONE    = 3'd2,
		OP_ACCUMULATE = 3'd3,
		OP_STORE      = 3'd4,
		OP_READ       = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic mem_rd;
		logic exec;
		logic div_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_read;
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

### hw/rtl/rab_if.sv
// ---------------------------------------------------------------------------
// Radiance accumulation buffer channel interfaces
// Sample request, pixel result and configuration write channels.
// ---------------------------------------------------------------------------
interface rab_item_if;
	import rab_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic [COORD_W-1:0]        x_pos;
	logic [COORD_W-1:0]        y_pos;
	logic signed [COLOR_W-1:0] red_in;
	logic signed [COLOR_W-1:0] green_in;
	logic signed [COLOR_W-1:0] blue_in;

	modport source (output valid, operation, x_pos, y_pos, red_in, green_in, blue_in,
		input ready);
	modport sink (input valid, operation, x_pos, y_pos, red_in, green_in, blue_in,
		output ready);
endinterface

interface rab_result_if;
	import rab_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;
	logic              count_zero;

	modport source (output valid, red_out, green_out, blue_out, count_zero, input ready);
	modport sink (input valid, red_out, green_out, blue_out, count_zero, output ready);
endinterface

interface rab_cfg_if;
	import rab_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [DIM_W-1:0]     wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

### hw/rtl/rab_div_lane.sv
// ---------------------------------------------------------------------------
// Radiance accumulation buffer divider lane
// Normalizes one channel sum by the sample count, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module rab_div_lane #(
	parameter int SUM_BITS = rab_pkg::SUM_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           start,
	input  logic                           step,
	input  logic [rab_pkg::DIV_STEP_W-1:0] shift,
	input  logic                           en,
	input  logic signed [SUM_BITS-1:0]     sum,
	input  logic [rab_pkg::CNT_W-1:0]      cnt,
	output logic [rab_pkg::CHAN_W-1:0]     q
);
	import rab_pkg::*;

	localparam int CMP_W = SUM_BITS + 1;

	logic                 pos;
	logic                 big;
	logic [31:0]          s32;
	logic [31:0]          full;
	logic [DIV_NUM_W-1:0] numer;
	logic [DIV_NUM_W-1:0] trial;
	logic [DIV_NUM_W-1:0] rem_q;
	logic [CHAN_W-1:0]    q_q;
	logic                 fixed_q;

	always_comb begin
		pos   = !sum[SUM_BITS-1] && (sum != '0);
		full  = {cnt, 16'b0};
		big   = CMP_W'($unsigned(sum)) >= CMP_W'(full);
		s32   = sum[31:0];
		// 2*s*65535 + cnt*65536 over a divisor of cnt*131072
		numer = (DIV_NUM_W'(s32) << 17) - (DIV_NUM_W'(s32) << 1) + (DIV_NUM_W'(cnt) << 16);
		trial = DIV_NUM_W'({cnt, 17'b0}) << shift;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= numer;
			q_q     <= (en && pos && big) ? '1 : '0;
			fixed_q <= !(en && pos && !big);
		end else if (step && !fixed_q && (rem_q >= trial)) begin
			rem_q      <= rem_q - trial;
			q_q[shift] <= 1'b1;
		end
	end

	assign q = q_q;
endmodule

### hw/rtl/rab_ctrl.sv
// ---------------------------------------------------------------------------
// Radiance accumulation buffer controller
// Sequences clear sweeps, memory fetch and execute, division and result hand-off.
// ---------------------------------------------------------------------------
module rab_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  rab_pkg::op_t        op,
	input  rab_pkg::dp_status_t status,
	output logic                ready,
	output rab_pkg::ctrl_cmd_t  cmd
);
	import rab_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (valid) begin
					case (op)
						OP_CLEAR:      state_nxt = ST_CLEAR;
						OP_ACCUMULATE: state_nxt = ST_FETCH;
						OP_STORE:      state_nxt = ST_FETCH;
						OP_READ:       state_nxt = ST_FETCH;
						default:       state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_FETCH: state_nxt = ST_EXEC;
			ST_EXEC: begin
				state_nxt = status.is_read ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (status.div_last) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		ready        = (state_q == ST_IDLE);
		cmd          = '0;
		cmd.load     = ready && valid;
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.mem_rd   = (state_q == ST_FETCH);
		cmd.exec     = (state_q == ST_EXEC);
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_DONE) && status.out_free;
	end
endmodule

### hw/rtl/rab_datapath.sv
// ---------------------------------------------------------------------------
// Radiance accumulation buffer datapath
// Sum memory, sample count, configuration, divider lanes and result register.
// ---------------------------------------------------------------------------
module rab_datapath #(
	parameter int MAX_WIDTH  = rab_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rab_pkg::MAX_HEIGHT_DEF,
	parameter int SUM_BITS   = rab_pkg::SUM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rab_pkg::ctrl_cmd_t                cmd,
	input  logic [rab_pkg::OP_W-1:0]          operation,
	input  logic [rab_pkg::COORD_W-1:0]       x_pos,
	input  logic [rab_pkg::COORD_W-1:0]       y_pos,
	input  logic signed [rab_pkg::COLOR_W-1:0] red_in,
	input  logic signed [rab_pkg::COLOR_W-1:0] green_in,
	input  logic signed [rab_pkg::COLOR_W-1:0] blue_in,
	output rab_pkg::dp_status_t               status,
	rab_cfg_if.sink                           cfg,
	rab_result_if.source                      pixels
);
	import rab_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CALC_W = (ADDR_W + 1 > 2 * DIM_W) ? ADDR_W + 1 : 2 * DIM_W;
	localparam int WORD_W = 3 * SUM_BITS;
	localparam int EXT_W  = SUM_BITS - COLOR_W;

	logic [WORD_W-1:0] sum_mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	logic [DIM_W-1:0]          width_q;
	logic [DIM_W-1:0]          height_q;
	logic [CNT_W-1:0]          count_q;
	op_t                       op_q;
	logic [ADDR_W-1:0]         addr_q;
	logic                      inside_q;
	logic signed [COLOR_W-1:0] red_q;
	logic signed [COLOR_W-1:0] green_q;
	logic signed [COLOR_W-1:0] blue_q;
	logic [CALC_W-1:0]         clr_idx_q;
	logic [CALC_W-1:0]         clr_lim_q;
	logic [DIV_STEP_W-1:0]     step_q;
	logic                      out_valid_q;
	logic [CHAN_W-1:0]         red_out_q;
	logic [CHAN_W-1:0]         green_out_q;
	logic [CHAN_W-1:0]         blue_out_q;
	logic                      count_zero_q;

	op_t                       op_in;
	logic [CALC_W-1:0]         addr_calc;
	logic [CALC_W-1:0]         area;
	logic                      clr_done;
	logic                      wr_en;
	logic [ADDR_W-1:0]         wr_addr;
	logic [WORD_W-1:0]         wr_data;
	logic signed [SUM_BITS-1:0] sum_r;
	logic signed [SUM_BITS-1:0] sum_g;
	logic signed [SUM_BITS-1:0] sum_b;
	logic signed [SUM_BITS-1:0] new_r;
	logic signed [SUM_BITS-1:0] new_g;
	logic signed [SUM_BITS-1:0] new_b;
	logic                      lane_start;
	logic                      read_ok;
	logic [CHAN_W-1:0]         q_r;
	logic [CHAN_W-1:0]         q_g;
	logic [CHAN_W-1:0]         q_b;

	function automatic logic signed [SUM_BITS-1:0] sext(input logic signed [COLOR_W-1:0] c);
		sext = {{EXT_W{c[COLOR_W-1]}}, c};
	endfunction

	function automatic logic signed [SUM_BITS-1:0] sat_add(
		input logic signed [SUM_BITS-1:0] s,
		input logic signed [COLOR_W-1:0]  c
	);
		logic signed [SUM_BITS:0] wide;
		wide = {s[SUM_BITS-1], s} + {{(EXT_W + 1){c[COLOR_W-1]}}, c};
		if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
			sat_add = wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
				: {1'b0, {(SUM_BITS-1){1'b1}}};
		end else begin
			sat_add = wide[SUM_BITS-1:0];
		end
	endfunction

	assign op_in     = op_t'(operation);
	assign addr_calc = CALC_W'(y_pos) * CALC_W'(width_q) + CALC_W'(x_pos);
	assign area      = CALC_W'(width_q) * CALC_W'(height_q);
	assign clr_done  = (clr_idx_q >= clr_lim_q);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg.valid) begin
			if (cfg.reg_index == REG_IMAGE_WIDTH) width_q <= cfg.wdata;
			if (cfg.reg_index == REG_IMAGE_HEIGHT) height_q <= cfg.wdata;
		end
	end

	// Count, latched operation, clear sweep bounds and division step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			clr_idx_q <= '0;
			clr_lim_q <= CALC_W'(DEPTH);
			op_q      <= OP_CLEAR;
			step_q    <= '0;
		end else begin
			if (cmd.load) begin
				op_q <= op_in;
				case (op_in)
					OP_CLEAR: begin
						count_q   <= '0;
						clr_idx_q <= '0;
						clr_lim_q <= (area > CALC_W'(DEPTH)) ? CALC_W'(DEPTH) : area;
					end
					OP_ADVANCE: begin
						if (count_q != '1) count_q <= count_q + CNT_W'(1);
					end
					OP_SET_ONE: count_q <= CNT_W'(1);
					default: ;
				endcase
			end
			if (cmd.clr_step && !clr_done) clr_idx_q <= clr_idx_q + CALC_W'(1);
			if (lane_start) begin
				step_q <= '1;
			end else if (cmd.div_step) begin
				step_q <= step_q - DIV_STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q   <= addr_calc[ADDR_W-1:0];
			inside_q <= (addr_calc < CALC_W'(DEPTH));
			red_q    <= red_in;
			green_q  <= green_in;
			blue_q   <= blue_in;
		end
	end

	always_comb begin
		sum_r = rdata_q[3*SUM_BITS-1:2*SUM_BITS];
		sum_g = rdata_q[2*SUM_BITS-1:SUM_BITS];
		sum_b = rdata_q[SUM_BITS-1:0];
		if (op_q == OP_ACCUMULATE) begin
			new_r = sat_add(sum_r, red_q);
			new_g = sat_add(sum_g, green_q);
			new_b = sat_add(sum_b, blue_q);
		end else begin
			new_r = sext(red_q);
			new_g = sext(green_q);
			new_b = sext(blue_q);
		end
		if (cmd.clr_step) begin
			wr_en   = !clr_done;
			wr_addr = clr_idx_q[ADDR_W-1:0];
			wr_data = '0;
		end else begin
			wr_en   = cmd.exec && inside_q
				&& ((op_q == OP_ACCUMULATE) || (op_q == OP_STORE));
			wr_addr = addr_q;
			wr_data = {new_r, new_g, new_b};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) sum_mem[wr_addr] <= wr_data;
		if (cmd.mem_rd) rdata_q <= sum_mem[addr_q];
	end

	assign lane_start = cmd.exec && (op_q == OP_READ);
	assign read_ok    = inside_q && (count_q != '0);

	rab_div_lane #(.SUM_BITS(SUM_BITS)) u_lane_r (
		.clk(clk), .start(lane_start), .step(cmd.div_step), .shift(step_q),
		.en(read_ok), .sum(sum_r), .cnt(count_q), .q(q_r)
	);
	rab_div_lane #(.SUM_BITS(SUM_BITS)) u_lane_g (
		.clk(clk), .start(lane_start), .step(cmd.div_step), .shift(step_q),
		.en(read_ok), .sum(sum_g), .cnt(count_q), .q(q_g)
	);
	rab_div_lane #(.SUM_BITS(SUM_BITS)) u_lane_b (
		.clk(clk), .start(lane_start), .step(cmd.div_step), .shift(step_q),
		.en(read_ok), .sum(sum_b), .cnt(count_q), .q(q_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (pixels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			red_out_q    <= q_r;
			green_out_q  <= q_g;
			blue_out_q   <= q_b;
			count_zero_q <= (count_q == '0);
		end
	end

	assign pixels.valid      = out_valid_q;
	assign pixels.red_out    = red_out_q;
	assign pixels.green_out  = green_out_q;
	assign pixels.blue_out   = blue_out_q;
	assign pixels.count_zero = count_zero_q;

	always_comb begin
		status          = '0;
		status.clr_done = clr_done;
		status.is_read  = (op_q == OP_READ);
		status.div_last = (step_q == '0);
		status.out_free = !out_valid_q || pixels.ready;
	end
endmodule

### hw/rtl/radiance_accumulation_buffer.sv
// ---------------------------------------------------------------------------
// Radiance accumulation buffer
// Per-pixel RGB radiance sums with one sample count, normalized on read.
// ---------------------------------------------------------------------------
//  channel   dir   carries
//  cfg       in    register index and write data (image width, image height)
//  samples   in    operation, pixel position, signed Q8.16 color
//  pixels    out   normalized 16-bit channels and zero-count flag
//
// Count operations complete in the idle state; accumulate and store pass through fetch and write.
// A read passes through fetch, prepare, 16 steps of the bit-serial divider and hand-off.
// Clear sweeps width*height memory entries (at most MAX_WIDTH*MAX_HEIGHT), one per cycle.
// After reset a sweep of all MAX_WIDTH*MAX_HEIGHT entries zeroes memory; samples waits.
// A finished read holds in the output register until pixels takes it.
module radiance_accumulation_buffer #(
	parameter int MAX_WIDTH  = rab_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rab_pkg::MAX_HEIGHT_DEF,
	parameter int SUM_BITS   = rab_pkg::SUM_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rab_cfg_if.sink      cfg,
	rab_item_if.sink     samples,
	rab_result_if.source pixels
);
	import rab_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       ready;

	rab_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.valid(samples.valid),
		.op(op_t'(samples.operation)),
		.status(status),
		.ready(ready),
		.cmd(cmd)
	);

	assign samples.ready = ready;

	rab_datapath #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.SUM_BITS(SUM_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.operation(samples.operation),
		.x_pos(samples.x_pos),
		.y_pos(samples.y_pos),
		.red_in(samples.red_in),
		.green_in(samples.green_in),
		.blue_in(samples.blue_in),
		.status(status),
		.cfg(cfg),
		.pixels(pixels)
	);

`include "radiance_accumulation_buffer_defines.svh"

	`RAB_ASSERT_NOW(a_no_result_overwrite, clk, arst_n, cmd.out_load, status.out_free)
	`RAB_ASSERT_NOW(a_result_from_load, clk, arst_n, $rose(pixels.valid), $past(cmd.out_load))
	`RAB_ASSERT_NEXT(a_read_blocks_input, clk, arst_n,
		cmd.load && (samples.operation == OP_READ), !samples.ready)
endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Radiance accumulation buffer testbench
// Drives sample requests through several image sizes and idling patterns,
// predicts every pixel read from a private copy of the sums and the count,
// and compares each returned pixel channel by channel.
// ---------------------------------------------------------------------------
import rab_pkg::*;

class pixel_scoreboard;
	typedef struct {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              zero_cnt;
	} pixel_t;

	longint      red_acc[int];
	longint      grn_acc[int];
	longint      blu_acc[int];
	int unsigned samples_seen;
	int unsigned width;
	int unsigned height;
	pixel_t      pending[$];
	int          errors;

	function new();
		width = 256;
		height = 256;
		samples_seen = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
		if (idx == REG_IMAGE_WIDTH) width = 32'(value);
		else if (idx == REG_IMAGE_HEIGHT) height = 32'(value);
	endfunction

	function longint sat_add(longint s, longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< 39) - 1;
		lo = -hi - 1;
		if (v > 0 && s > hi - v) return hi;
		if (v < 0 && s < lo - v) return lo;
		return s + v;
	endfunction

	function logic [CHAN_W-1:0] scale(longint s);
		longint full;
		full = longint'(samples_seen) * 65536;
		if (s <= 0) return '0;
		if (s >= full) return 16'hFFFF;
		return CHAN_W'((2 * s * 65535 + full) / (2 * full));
	endfunction

	function longint fetch(ref longint arr[int], input int a);
		return arr.exists(a) ? arr[a] : 0;
	endfunction

	function void note(logic [OP_W-1:0] op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic signed [COLOR_W-1:0] r, logic signed [COLOR_W-1:0] g,
			logic signed [COLOR_W-1:0] b);
		int unsigned a;
		int unsigned n;
		bit          in_mem;
		int          doomed[$];
		pixel_t      px;
		a = y * width + x;
		in_mem = a < 65536;
		case (op)
			OP_CLEAR: begin
				n = width * height;
				foreach (red_acc[k]) if (k < n) doomed.push_back(k);
				foreach (doomed[i]) begin
					red_acc.delete(doomed[i]);
					grn_acc.delete(doomed[i]);
					blu_acc.delete(doomed[i]);
				end
				samples_seen = 0;
			end
			OP_ADVANCE: if (samples_seen < 65535) samples_seen++;
			OP_SET_ONE: samples_seen = 1;
			OP_ACCUMULATE: if (in_mem) begin
				red_acc[a] = sat_add(fetch(red_acc, a), r);
				grn_acc[a] = sat_add(fetch(grn_acc, a), g);
				blu_acc[a] = sat_add(fetch(blu_acc, a), b);
			end
			OP_STORE: if (in_mem) begin
				red_acc[a] = r;
				grn_acc[a] = g;
				blu_acc[a] = b;
			end
			OP_READ: begin
				px.red = '0;
				px.green = '0;
				px.blue = '0;
				px.zero_cnt = samples_seen == 0;
				if (samples_seen != 0 && in_mem) begin
					px.red = scale(fetch(red_acc, a));
					px.green = scale(fetch(grn_acc, a));
					px.blue = scale(fetch(blu_acc, a));
				end
				pending.push_back(px);
			end
			default: ;
		endcase
	endfunction

	function void check(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
			logic cz);
		pixel_t px;
		if (pending.size() == 0) begin
			$display("%0t: unexpected pixel r=%h g=%h b=%h z=%b", $time, r, g, b, cz);
			errors++;
			return;
		end
		px = pending.pop_front();
		if (r !== px.red) begin
			$display("%0t: red expected %h actual %h", $time, px.red, r);
			errors++;
		end
		if (g !== px.green) begin
			$display("%0t: green expected %h actual %h", $time, px.green, g);
			errors++;
		end
		if (b !== px.blue) begin
			$display("%0t: blue expected %h actual %h", $time, px.blue, b);
			errors++;
		end
		if (cz !== px.zero_cnt) begin
			$display("%0t: count_zero expected %b actual %b", $time, px.zero_cnt, cz);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int IDLE_LIMIT = 300000;
	localparam logic signed [COLOR_W-1:0] COLOR_MAX = 24'sh7FFFFF;
	localparam logic signed [COLOR_W-1:0] COLOR_MIN = -24'sh800000;

	logic clk;
	logic arst_n;

	rab_cfg_if    cfg_if();
	rab_item_if   smp_if();
	rab_result_if pix_if();

	radiance_accumulation_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.samples(smp_if),
		.pixels(pix_if)
	);

	pixel_scoreboard sb = new();

	int  send_gap_pct;
	int  stall_pct;
	bit  hold_req;
	bit  hold_done;
	int  hold_left;
	int  quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.reg_index = '0;
		cfg_if.wdata = '0;
		smp_if.valid = 1'b0;
		smp_if.operation = '0;
		smp_if.x_pos = '0;
		smp_if.y_pos = '0;
		smp_if.red_in = '0;
		smp_if.green_in = '0;
		smp_if.blue_in = '0;
		pix_if.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// result side: check on handshake, then pick next ready
	always @(posedge clk) begin
		if (pix_if.valid && pix_if.ready)
			sb.check(pix_if.red_out, pix_if.green_out, pix_if.blue_out, pix_if.count_zero);
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			pix_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pix_if.ready <= 1'b0;
		end else begin
			pix_if.ready <= $urandom_range(99) >= stall_pct;
		end
	end

	always @(posedge clk) begin
		if ((smp_if.valid && smp_if.ready) || (pix_if.valid && pix_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[radiance_accumulation_buffer] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
		int drain;
		// drop the last request so it is not taken twice
		smp_if.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		// a clear may still be sweeping with nothing left to return
		drain = sb.width * sb.height;
		if (drain > 65536) drain = 65536;
		repeat (drain + 50) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.reg_index <= idx;
		cfg_if.wdata <= value;
		do @(posedge clk); while (!cfg_if.ready);
		sb.set_reg(idx, value);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic send(logic [OP_W-1:0] op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic signed [COLOR_W-1:0] r, logic signed [COLOR_W-1:0] g,
			logic signed [COLOR_W-1:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			smp_if.valid <= 1'b0;
			@(posedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.operation <= op;
		smp_if.x_pos <= x;
		smp_if.y_pos <= y;
		smp_if.red_in <= r;
		smp_if.green_in <= g;
		smp_if.blue_in <= b;
		do @(posedge clk); while (!smp_if.ready);
		sb.note(op, x, y, r, g, b);
	endtask

	function automatic logic signed [COLOR_W-1:0] pick_color();
		case ($urandom_range(9))
			0: return COLOR_MAX;
			1: return COLOR_MIN;
			2, 3, 4: return COLOR_W'($urandom_range(32'h20000));
			5: return -$signed(COLOR_W'($urandom_range(32'h4000)));
			default: return COLOR_W'($urandom);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(int unsigned span);
		int unsigned lim;
		case ($urandom_range(9))
			0: lim = 255;
			1, 2, 3: lim = (span == 0 || span > 256) ? 255 : span - 1;
			default: lim = (span == 0) ? 0 : ((span > 8) ? 7 : span - 1);
		endcase
		return COORD_W'($urandom_range(lim));
	endfunction

	task automatic random_items(int n, bit clear_ok);
		logic [OP_W-1:0] op;
		int              pick;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 2) op = clear_ok ? OP_CLEAR : OP_ADVANCE;
			else if (pick < 12) op = OP_ADVANCE;
			else if (pick < 17) op = OP_SET_ONE;
			else if (pick < 45) op = OP_ACCUMULATE;
			else if (pick < 60) op = OP_STORE;
			else if (pick < 97) op = OP_READ;
			else op = pick[0] ? OP_SPARE_LO : OP_SPARE_HI;
			send(op, pick_coord(sb.width), pick_coord(sb.height),
				pick_color(), pick_color(), pick_color());
		end
	endtask

	initial begin
		int unsigned widths[9] = '{256, 4, 1, 16, 256, 1, 511, 0, 32};
		int unsigned heights[9] = '{256, 4, 1, 8, 1, 256, 511, 0, 32};
		bit          big;
		send_gap_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		@(posedge arst_n);
		@(posedge clk);

		// zero count read, extremes, both count ops, column wrap
		send(OP_READ, 8'd0, 8'd0, '0, '0, '0);
		send(OP_READ, 8'd255, 8'd255, '0, '0, '0);
		send(OP_STORE, 8'd255, 8'd255, COLOR_MAX, COLOR_MIN, 24'sh010000);
		send(OP_SET_ONE, '0, '0, '0, '0, '0);
		send(OP_READ, 8'd255, 8'd255, '0, '0, '0);
		send(OP_ACCUMULATE, 8'd0, 8'd1, 24'sh008000, 24'sh000001, COLOR_MAX);
		send(OP_ACCUMULATE, 8'd0, 8'd1, 24'sh008000, COLOR_MIN, COLOR_MAX);
		send(OP_ADVANCE, '0, '0, '0, '0, '0);
		send(OP_ADVANCE, '0, '0, '0, '0, '0);
		send(OP_READ, 8'd0, 8'd1, '0, '0, '0);
		send(OP_SPARE_LO, 8'd0, 8'd1, COLOR_MAX, COLOR_MAX, COLOR_MAX);
		send(OP_SPARE_HI, 8'd0, 8'd1, COLOR_MAX, COLOR_MAX, COLOR_MAX);
		send(OP_READ, 8'd0, 8'd1, '0, '0, '0);
		send(OP_CLEAR, '0, '0, '0, '0, '0);
		send(OP_READ, 8'd0, 8'd1, '0, '0, '0);
		send(OP_SET_ONE, '0, '0, '0, '0, '0);
		send(OP_READ, 8'd0, 8'd1, '0, '0, '0);

		for (int p = 0; p < 9; p++) begin
			if (p != 0) begin
				write_reg(REG_IMAGE_WIDTH, DIM_W'(widths[p]));
				write_reg(REG_IMAGE_HEIGHT, DIM_W'(heights[p]));
			end
			send_gap_pct = (p % 4 == 1) ? 83 : (p % 4 == 3) ? 28 : 0;
			stall_pct = (p % 4 == 2) ? 83 : (p % 4 == 3) ? 28 : 0;
			big = widths[p] * heights[p] > 4096;
			if (p == 6) begin
				// past the storage: writes dropped, reads zero
				send(OP_SET_ONE, '0, '0, '0, '0, '0);
				send(OP_STORE, 8'd255, 8'd255, COLOR_MAX, COLOR_MAX, COLOR_MAX);
				send(OP_ACCUMULATE, 8'd255, 8'd255, COLOR_MAX, COLOR_MAX, COLOR_MAX);
				send(OP_READ, 8'd255, 8'd255, '0, '0, '0);
			end
			if (p == 1) begin
				send(OP_STORE, 8'd10, 8'd0, 24'sh00C000, 24'sh004000, 24'sh000000);
				send(OP_READ, 8'd2, 8'd2, '0, '0, '0);
			end
			if (p == 7) send(OP_CLEAR, '0, '0, '0, '0, '0);
			if (p == 2) begin
				stall_pct = 0;
				hold_req = 1'b1;
				random_items(60, 1'b1);
			end
			random_items(160, !big);
		end

		send_gap_pct = 0;
		smp_if.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("[radiance_accumulation_buffer] OK");
		else
			$display("[radiance_accumulation_buffer] ERROR");
		$finish;
	end
endmodule
